// ===== rtl/binary_delta_patch_apply_top_macros.svh =====
// assertion macros shared by the patch applier checker
// no dependencies; guarded against double inclusion
`ifndef BINARY_DELTA_PATCH_APPLY_TOP_MACROS_SVH
`define BINARY_DELTA_PATCH_APPLY_TOP_MACROS_SVH

// same-cycle implication, ignored while in reset
`define BDPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bdpa check failed");

// next-cycle implication, ignored while in reset
`define BDPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bdpa check failed");

// next-cycle implication, also checked across reset
`define BDPA_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("bdpa check failed");

`endif

// ===== rtl/bdpa_pkg.sv =====
// types, codes and widths for the delta patch applier
// used by every rtl module of the block; no dependencies
`default_nettype none

package bdpa_pkg;

    localparam int POS_BITS_DEF = 32;

    localparam int S_TDATA_W = 216;
    localparam int S_USED_W  = 209;
    localparam int M_TDATA_W = 80;
    localparam int M_USED_W  = 77;

    localparam logic [1:0] FUNC_CTRL  = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_EXTRA = 2'd2;
    localparam logic [1:0] EXP_DONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_KIND = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    typedef enum logic [3:0] {
        PH_CTRL  = 4'b0001,
        PH_ADD   = 4'b0010,
        PH_EXTRA = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    // input word, lowest field last
    typedef struct packed {
        logic [1:0]  func;
        logic        old_present;
        logic [7:0]  old_byte;
        logic [7:0]  patch_byte;
        logic [63:0] seek_raw;
        logic [63:0] copy_raw;
        logic [63:0] add_raw;
    } item_t;

    // result word, lowest field last
    typedef struct packed {
        logic [31:0] out_pos;
        logic [1:0]  status;
        logic [1:0]  expecting;
        logic [32:0] old_addr;
        logic [7:0]  new_byte;
    } res_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_CTRL:  code = FUNC_CTRL;
            PH_ADD:   code = FUNC_ADD;
            PH_EXTRA: code = FUNC_EXTRA;
            PH_DONE:  code = EXP_DONE;
            default:  code = FUNC_CTRL;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bdpa_in_reg.sv =====
// input register stage: captures one stream word per cycle while adv is high or the register is empty
// depends on bdpa_pkg
`default_nettype none

module bdpa_in_reg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [bdpa_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           adv,
    output      logic                           item_valid,
    output      bdpa_pkg::item_t                item
);

    logic            valid_reg;
    logic            valid_next;
    bdpa_pkg::item_t item_reg;
    logic            take;

    assign s_tready   = !valid_reg || adv;
    assign take       = s_tvalid && s_tready;
    assign valid_next = take || (valid_reg && !adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= bdpa_pkg::item_t'({s_tuser, s_tdata[bdpa_pkg::S_USED_W-1:0]});
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/bdpa_core.sv =====
// patch state, per-word update and result register
// depends on bdpa_pkg
`default_nettype none

module bdpa_core #(
    parameter int POS_BITS = bdpa_pkg::POS_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           item_valid,
    input  wire bdpa_pkg::item_t                item,
    output      logic                           adv,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [31:0]                    cfg_data,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [bdpa_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic                           m_tuser
);

    localparam int OW = POS_BITS + 1;
    localparam int MW = POS_BITS + 2;
    localparam int SW = POS_BITS + 3;
    localparam logic signed [OW-1:0] OLD_MAX = {1'b0, {POS_BITS{1'b1}}};
    localparam logic signed [OW-1:0] OLD_MIN = {1'b1, {POS_BITS{1'b0}}};
    localparam logic [MW-1:0]        SEEK_CLAMP = {1'b1, {(POS_BITS + 1){1'b0}}};

    bdpa_pkg::phase_t      phase_reg, phase_next;
    logic                  err_reg, err_next;
    logic [1:0]            code_reg, code_next;
    logic [POS_BITS-1:0]   add_left_reg, add_left_next;
    logic [POS_BITS-1:0]   extra_left_reg, extra_left_next;
    logic signed [SW-1:0]  seek_reg, seek_next;
    logic signed [OW-1:0]  old_reg, old_next;
    logic [31:0]           new_reg, new_next;
    logic [31:0]           size_reg;
    logic                  m_valid_reg, m_valid_next;
    bdpa_pkg::res_t        res_reg, res_next;
    logic                  bv_reg, bv_next;

    logic                  fire;
    logic                  a_bad, c_bad, s_big;
    logic [MW-1:0]         s_mag;
    logic signed [SW-1:0]  seek_dec, seek_use, tri_sum;
    logic signed [OW-1:0]  old_inc, old_base, old_tri;
    logic [31:0]           new_inc, new_base;
    bdpa_pkg::phase_t      tri_phase;
    logic [7:0]            nb;

    assign adv       = !m_valid_reg || m_tready;
    assign fire      = item_valid && adv;
    assign cfg_ready = 1'b1;

    // sign-magnitude decode; minus zero is zero
    assign a_bad = (item.add_raw[63] && (|item.add_raw[62:0])) ||
                   (|item.add_raw[62:POS_BITS]);
    assign c_bad = (item.copy_raw[63] && (|item.copy_raw[62:0])) ||
                   (|item.copy_raw[62:POS_BITS]);
    assign s_big = (|item.seek_raw[62:POS_BITS+2]) ||
                   (item.seek_raw[POS_BITS+1] && (|item.seek_raw[POS_BITS:0]));
    assign s_mag    = s_big ? SEEK_CLAMP : item.seek_raw[POS_BITS+1:0];
    assign seek_dec = item.seek_raw[63] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

    // end-of-run position and completion check
    assign old_inc   = (old_reg == OLD_MAX) ? old_reg : old_reg + OW'(1);
    assign old_base  = (phase_reg == bdpa_pkg::PH_ADD) ? old_inc : old_reg;
    assign seek_use  = (phase_reg == bdpa_pkg::PH_CTRL) ? seek_dec : seek_reg;
    assign tri_sum   = SW'(old_base) + seek_use;
    assign old_tri   = (tri_sum > SW'(OLD_MAX)) ? OLD_MAX :
                       (tri_sum < SW'(OLD_MIN)) ? OLD_MIN : OW'(tri_sum);
    assign new_inc   = (new_reg == 32'hFFFF_FFFF) ? new_reg : new_reg + 32'd1;
    assign new_base  = (phase_reg == bdpa_pkg::PH_CTRL) ? new_reg : new_inc;
    assign tri_phase = (new_base >= size_reg) ? bdpa_pkg::PH_DONE : bdpa_pkg::PH_CTRL;

    always_comb begin
        phase_next      = phase_reg;
        err_next        = err_reg;
        code_next       = code_reg;
        add_left_next   = add_left_reg;
        extra_left_next = extra_left_reg;
        seek_next       = seek_reg;
        old_next        = old_reg;
        new_next        = new_reg;
        nb              = 8'd0;
        bv_next         = 1'b0;
        if (fire && !err_reg && phase_reg != bdpa_pkg::PH_DONE) begin
            if (item.func != bdpa_pkg::phase_code(phase_reg)) begin
                err_next  = 1'b1;
                code_next = bdpa_pkg::ST_BAD_KIND;
            end else begin
                case (phase_reg)
                    bdpa_pkg::PH_CTRL: begin
                        if (a_bad || c_bad) begin
                            err_next  = 1'b1;
                            code_next = bdpa_pkg::ST_BAD_LEN;
                        end else begin
                            add_left_next   = item.add_raw[POS_BITS-1:0];
                            extra_left_next = item.copy_raw[POS_BITS-1:0];
                            seek_next       = seek_dec;
                            if (|item.add_raw[POS_BITS-1:0]) begin
                                phase_next = bdpa_pkg::PH_ADD;
                            end else if (|item.copy_raw[POS_BITS-1:0]) begin
                                phase_next = bdpa_pkg::PH_EXTRA;
                            end else begin
                                old_next   = old_tri;
                                seek_next  = '0;
                                phase_next = tri_phase;
                            end
                        end
                    end
                    bdpa_pkg::PH_ADD: begin
                        nb            = item.patch_byte + (item.old_present ? item.old_byte : 8'd0);
                        bv_next       = 1'b1;
                        old_next      = old_inc;
                        new_next      = new_inc;
                        add_left_next = add_left_reg - POS_BITS'(1);
                        if (add_left_reg == POS_BITS'(1)) begin
                            if (|extra_left_reg) begin
                                phase_next = bdpa_pkg::PH_EXTRA;
                            end else begin
                                old_next   = old_tri;
                                seek_next  = '0;
                                phase_next = tri_phase;
                            end
                        end
                    end
                    bdpa_pkg::PH_EXTRA: begin
                        nb              = item.patch_byte;
                        bv_next         = 1'b1;
                        new_next        = new_inc;
                        extra_left_next = extra_left_reg - POS_BITS'(1);
                        if (extra_left_reg == POS_BITS'(1)) begin
                            old_next   = old_tri;
                            seek_next  = '0;
                            phase_next = tri_phase;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        res_next.new_byte  = nb;
        res_next.old_addr  = 33'(old_next);
        res_next.expecting = bdpa_pkg::phase_code(phase_next);
        res_next.out_pos   = new_next;
        if (err_next) begin
            res_next.status = code_next;
        end else if (phase_next == bdpa_pkg::PH_DONE) begin
            res_next.status = bdpa_pkg::ST_DONE;
        end else begin
            res_next.status = bdpa_pkg::ST_OK;
        end
    end

    assign m_valid_next = fire || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= bdpa_pkg::PH_CTRL;
            err_reg        <= 1'b0;
            code_reg       <= bdpa_pkg::ST_OK;
            add_left_reg   <= '0;
            extra_left_reg <= '0;
            seek_reg       <= '0;
            old_reg        <= '0;
            new_reg        <= '0;
            size_reg       <= 32'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            err_reg        <= err_next;
            code_reg       <= code_next;
            add_left_reg   <= add_left_next;
            extra_left_reg <= extra_left_next;
            seek_reg       <= seek_next;
            old_reg        <= old_next;
            new_reg        <= new_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
            bv_reg  <= bv_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(bdpa_pkg::M_TDATA_W - bdpa_pkg::M_USED_W){1'b0}}, res_reg};
    assign m_tuser  = bv_reg;

endmodule

`default_nettype wire

// ===== rtl/binary_delta_patch_apply_top.sv =====
// a word waits in the input register; its result word is then registered onto m_tvalid
// one word per cycle unless m_tready stalls: input register, update logic, result register
// the update of patch state for a word completes before the next word reaches it
// reset: synchronous active-low aresetn clears state, positions, error and flags;
// the image size returns to 1; no clearing pass, ready on the first cycle after reset
`default_nettype none

module binary_delta_patch_apply_top #(
    parameter int POS_BITS = bdpa_pkg::POS_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // add_raw[63:0] copy_raw[127:64] seek_raw[191:128] patch_byte[199:192]
    // old_byte[207:200] old_present[208], zero fill above
    input  wire logic [bdpa_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]                     s_tuser,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // new_byte[7:0] old_addr[40:8] expecting[42:41] status[44:43]
    // out_pos[76:45], zero fill above
    output      logic [bdpa_pkg::M_TDATA_W-1:0] m_tdata,
    // byte_valid
    output      logic                           m_tuser,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [31:0]                    cfg_data
);

    logic            item_valid;
    logic            adv;
    bdpa_pkg::item_t item;

    bdpa_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    bdpa_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .adv        (adv),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/bdpa_checker.sv =====
// port-level checks on the patch applier, bound to the top level
// depends on bdpa_pkg and binary_delta_patch_apply_top_macros.svh
`default_nettype none

`include "binary_delta_patch_apply_top_macros.svh"

module bdpa_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bdpa_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    bdpa_pkg::res_t res;
    logic           is_done;
    logic           is_finished;
    logic           is_err;

    assign res         = bdpa_pkg::res_t'(m_tdata[bdpa_pkg::M_USED_W-1:0]);
    assign is_done     = (res.status == bdpa_pkg::ST_DONE);
    assign is_finished = (res.expecting == bdpa_pkg::EXP_DONE);
    assign is_err      = (res.status == bdpa_pkg::ST_BAD_LEN) ||
                         (res.status == bdpa_pkg::ST_BAD_KIND);

    `BDPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BDPA_ASSERT_NOW(a_done_shows_done, m_tvalid && is_done, is_finished)
    `BDPA_ASSERT_NOW(a_no_byte_on_error, m_tvalid && m_tuser, !is_err)
    `BDPA_ASSERT_NEXT_RST(a_reset_empties, !aresetn, !m_tvalid)

endmodule

bind binary_delta_patch_apply_top bdpa_checker u_bdpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
